// ===== sv/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// shared widths and constants of the modular exponentiator
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned OPERAND_BITS = 32;
  localparam int unsigned CNT_BITS     = $clog2(OPERAND_BITS);

  localparam int unsigned IN_BITS      = 3 * OPERAND_BITS;
  localparam int unsigned IN_BYTES     = (IN_BITS + 7) / 8;
  localparam int unsigned IN_TDATA_W   = 8 * IN_BYTES;

  localparam int unsigned OUT_BITS     = OPERAND_BITS + 1;
  localparam int unsigned OUT_BYTES    = (OUT_BITS + 7) / 8;
  localparam int unsigned OUT_TDATA_W  = 8 * OUT_BYTES;

  typedef logic [OPERAND_BITS-1:0] operand_t;

endpackage

// ===== sv/modular_exponentiator_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiator_core
// base^exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// input channel s_axis: one transaction carries base, exponent and modulus.
// output channel m_axis: one transaction per input carries power_mod and
// modulus_error.
// every modular product runs through one shared double-and-add reducer that
// takes one multiplier bit per cycle. the base is first reduced by the same
// unit, then each set exponent bit costs one product, and each exponent bit
// below the highest set bit costs a square. work stops once no set exponent
// bits remain. one item is worked on at a time.
// a new item is accepted while the previous result still waits in the output
// register; a finished result waits inside until that register is free, so a
// stalled receiver holds the core after at most one further item.
// reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module modular_exponentiator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // base, exponent, modulus
  input  logic [modexp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // power_mod, modulus_error, zero fill
  output logic [modexp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import modexp_pkg::*;

  localparam int unsigned W = OPERAND_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_e;

  state_e               state_q, state_d;
  operand_t             m_q, m_d;
  operand_t             e_q, e_d;
  operand_t             b_q, b_d;
  operand_t             r_q, r_d;
  logic                 err_q, err_d;
  operand_t             mx_q, mx_d;
  operand_t             my_q, my_d;
  operand_t             macc_q, macc_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 ovalid_q, ovalid_d;
  operand_t             opow_q, opow_d;
  logic                 oerr_q, oerr_d;

  operand_t             in_base, in_exp, in_mod;
  logic [W+1:0]         step_t;
  logic [W+2:0]         step_d1, step_d2;
  operand_t             step_res;
  logic                 last_step;
  operand_t             e_next;
  logic                 out_free;

  assign in_base = s_axis_tdata_i[W-1:0];
  assign in_exp  = s_axis_tdata_i[2*W-1:W];
  assign in_mod  = s_axis_tdata_i[3*W-1:2*W];

  // one double-and-add step: 2*acc + bit*x, brought below m
  always_comb begin
    step_t   = {1'b0, macc_q, 1'b0} + (my_q[W-1] ? {2'b00, mx_q} : '0);
    step_d1  = {1'b0, step_t} - {3'b000, m_q};
    step_d2  = {1'b0, step_t} - {2'b00, m_q, 1'b0};
    if (!step_d2[W+2]) begin
      step_res = step_d2[W-1:0];
    end else if (!step_d1[W+2]) begin
      step_res = step_d1[W-1:0];
    end else begin
      step_res = step_t[W-1:0];
    end
  end

  assign last_step = (cnt_q == CNT_BITS'(W - 1));
  assign e_next    = {1'b0, e_q[W-1:1]};
  assign out_free  = !ovalid_q || m_axis_tready_i;

  always_comb begin
    state_d  = state_q;
    m_d      = m_q;
    e_d      = e_q;
    b_d      = b_q;
    r_d      = r_q;
    err_d    = err_q;
    mx_d     = mx_q;
    my_d     = {my_q[W-2:0], 1'b0};
    macc_d   = step_res;
    cnt_d    = cnt_q + CNT_BITS'(1);
    ovalid_d = ovalid_q && !m_axis_tready_i;
    opow_d   = opow_q;
    oerr_d   = oerr_q;

    case (state_q)
      ST_IDLE: begin
        macc_d = macc_q;
        cnt_d  = cnt_q;
        my_d   = my_q;
        if (s_axis_tvalid_i) begin
          m_d    = in_mod;
          e_d    = in_exp;
          r_d    = operand_t'(1);
          macc_d = '0;
          cnt_d  = '0;
          if (in_mod == '0) begin
            err_d   = 1'b1;
            r_d     = '0;
            state_d = ST_FIN;
          end else begin
            err_d   = 1'b0;
            mx_d    = (in_mod == operand_t'(1)) ? '0 : operand_t'(1);
            my_d    = in_base;
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (last_step) begin
          b_d    = step_res;
          macc_d = '0;
          cnt_d  = '0;
          if (e_q == '0) begin
            state_d = ST_FIN;
          end else if (e_q[0]) begin
            mx_d    = step_res;
            my_d    = r_q;
            state_d = ST_MUL;
          end else begin
            mx_d    = step_res;
            my_d    = step_res;
            state_d = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        if (last_step) begin
          r_d    = step_res;
          macc_d = '0;
          cnt_d  = '0;
          if (e_next == '0) begin
            state_d = ST_FIN;
          end else begin
            mx_d    = b_q;
            my_d    = b_q;
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (last_step) begin
          b_d    = step_res;
          e_d    = e_next;
          macc_d = '0;
          cnt_d  = '0;
          mx_d   = step_res;
          if (e_next == '0) begin
            state_d = ST_FIN;
          end else if (e_next[0]) begin
            my_d    = r_q;
            state_d = ST_MUL;
          end else begin
            my_d    = step_res;
            state_d = ST_SQR;
          end
        end
      end
      ST_FIN: begin
        macc_d = macc_q;
        cnt_d  = cnt_q;
        my_d   = my_q;
        if (out_free) begin
          ovalid_d = 1'b1;
          opow_d   = r_q;
          oerr_d   = err_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      m_q      <= m_d;
      e_q      <= e_d;
      b_q      <= b_d;
      r_q      <= r_d;
      err_q    <= err_d;
      mx_q     <= mx_d;
      my_q     <= my_d;
      macc_q   <= macc_d;
      cnt_q    <= cnt_d;
      opow_q   <= opow_d;
      oerr_q   <= oerr_d;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_BITS)'(0), oerr_q, opow_q};

  // partial product and multiplicand stay reduced while a product runs
  property p_acc_reduced;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR)
      |-> (macc_q < m_q && mx_q < m_q);
  endproperty
  a_acc_reduced: assert property (p_acc_reduced)
    else $error("modexp: partial product not below modulus");

  // an error result always carries a zero value
  property p_err_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && m_axis_tdata_o[OPERAND_BITS])
      |-> (m_axis_tdata_o[OPERAND_BITS-1:0] == '0);
  endproperty
  a_err_zero: assert property (p_err_zero)
    else $error("modexp: error result with nonzero value");

  // a result leaves the finish state only into a free output register
  property p_fin_to_out;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_FIN && ovalid_q && !m_axis_tready_i)
      |=> (state_q == ST_FIN);
  endproperty
  a_fin_to_out: assert property (p_fin_to_out)
    else $error("modexp: result overwrote a pending output");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for modular_exponentiator_core
// ----------------------------------------------------------------------------
// each accepted input transaction is run through a square-and-multiply
// predictor, and the expected result is queued in a scoreboard. every output
// transaction is checked field by field against the oldest entry. the
// stimulus is a directed set of corner cases followed by random operands,
// with random gaps on the sender side and random stalls on the receiver side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import modexp_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 260;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 100;

  class modexp_scoreboard;
    typedef struct {
      operand_t base;
      operand_t exponent;
      operand_t modulus;
      operand_t power_mod;
      logic     modulus_error;
    } modexp_result_t;

    modexp_result_t expected_q[$];
    int errors = 0;

    function modexp_result_t predict_power(operand_t b, operand_t e, operand_t m);
      modexp_result_t r;
      longint unsigned mod_w;
      longint unsigned sq;
      longint unsigned acc;
      r.base     = b;
      r.exponent = e;
      r.modulus  = m;
      if (m == '0) begin
        r.power_mod     = '0;
        r.modulus_error = 1'b1;
        return r;
      end
      mod_w = longint'(m);
      sq    = longint'(b) % mod_w;
      acc   = 1;
      for (int i = 0; i < OPERAND_BITS; i++) begin
        if (e[i]) begin
          acc = (acc * sq) % mod_w;
        end
        sq = (sq * sq) % mod_w;
      end
      r.power_mod     = operand_t'(acc);
      r.modulus_error = 1'b0;
      return r;
    endfunction

    function void note_request(operand_t b, operand_t e, operand_t m);
      expected_q.push_back(predict_power(b, e, m));
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] word);
      modexp_result_t exp_r;
      operand_t       got_pow;
      logic           got_err;
      got_pow = word[OPERAND_BITS-1:0];
      got_err = word[OPERAND_BITS];
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result power_mod=%0h modulus_error=%0b",
                         got_pow, got_err));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got_pow !== exp_r.power_mod || got_err !== exp_r.modulus_error) begin
        report($sformatf("b=%0h e=%0h m=%0h: got %0h/%0b, expected %0h/%0b",
                         exp_r.base, exp_r.exponent, exp_r.modulus, got_pow, got_err,
                         exp_r.power_mod, exp_r.modulus_error));
      end
    endtask
  endclass

  logic                   clk     = 1'b0;
  logic                   rst_n   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tready = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int unsigned      cycle_count = 0;
  int               send_calm   = 0;
  int               recv_calm   = 0;
  modexp_scoreboard sb          = new();

  modular_exponentiator_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // idle cycles before a transaction, with occasional stretches of none
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 24);
    end
    return $urandom_range(0, 3);
  endfunction

  task send_operands(operand_t b, operand_t e, operand_t m);
    logic [IN_TDATA_W-1:0] word;
    int                    gap;
    word = '0;
    word[OPERAND_BITS-1:0]                = b;
    word[2*OPERAND_BITS-1:OPERAND_BITS]   = e;
    word[3*OPERAND_BITS-1:2*OPERAND_BITS] = m;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_request(b, e, m);
  endtask

  task send_random_operands();
    operand_t b;
    operand_t e;
    operand_t m;
    case ($urandom_range(0, 15))
      0:       m = '0;
      1:       m = 1;
      2, 3, 4: m = $urandom_range(2, 1000);
      5:       m = '1 - $urandom_range(0, 7);
      default: m = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0:       e = $urandom;
      1:       e = $urandom_range(0, 15);
      default: e = $urandom_range(0, 65535);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      b = $urandom_range(0, 3);
    end else begin
      b = $urandom;
    end
    send_operands(b, e, m);
  endtask

  // receiver: random stall, then take one transaction and check it
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      sb.check_result(m_tdata);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero modulus
    send_operands(32'h0, 32'h0, 32'h0);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    // modulus one, with and without exponent
    send_operands(32'h5, 32'h0, 32'h1);
    send_operands(32'h5, 32'h3, 32'h1);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
    // zero exponent and zero base
    send_operands(32'h0, 32'h0, 32'h7);
    send_operands(32'h0, 32'h5, 32'h7);
    send_operands(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    // extreme operands
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'h2, 32'hFFFF_FFFB);
    send_operands(32'h1234_5678, 32'hFFFF_FFFF, 32'h2);
    send_operands(32'h7, 32'h8000_0000, 32'hFFFF_FFF1);
    send_operands(32'h1, 32'hFFFF_FFFF, 32'h10);
    // base equal to, multiple of and above the modulus
    send_operands(32'h7, 32'h1, 32'h7);
    send_operands(32'hE, 32'h1, 32'h7);
    send_operands(32'h64, 32'h1, 32'h7);
    send_operands(32'h2, 32'hA, 32'h3E8);
    send_operands(32'h3, 32'hC8, 32'hD);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFE);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_random_operands();
    end
    s_tvalid <= 1'b0;

    while (sb.outstanding() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiator_core.f =====
sv/modexp_pkg.sv
sv/modular_exponentiator_core.sv
test/tb_top.sv
